@@ src/mbe_pkg.sv @@
// Shared constants, types and state codes for the escape-time unit.
package mbe_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 16;
  localparam int C_W         = 32;
  localparam int Z_W         = 36;
  localparam int THR_W       = 32;
  localparam int DIGIT_W     = 9;
  localparam int NUM_CELLS   = Z_W / DIGIT_W;
  localparam int ACC_W       = Z_W + DIGIT_W + 1;
  localparam int FULL_W      = ACC_W + Z_W;
  localparam int SQ_W        = 48;
  localparam int IDX_W       = 2;

  localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

  localparam logic [IDX_W-1:0] REG_LIMIT     = 2'd0;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_STEP
  } state_t;

  // Data handed from one multiplier cell to the next
  typedef struct packed {
    logic                    valid;
    logic signed [Z_W-1:0]   x_re;
    logic signed [Z_W-1:0]   x_im;
    logic signed [Z_W-1:0]   y_re;
    logic signed [Z_W-1:0]   y_im;
    logic signed [ACC_W-1:0] hi_aa;
    logic signed [ACC_W-1:0] hi_bb;
    logic signed [ACC_W-1:0] hi_ab;
    logic [Z_W-1:0]          lo_aa;
    logic [Z_W-1:0]          lo_bb;
    logic [Z_W-1:0]          lo_ab;
  } cell_t;

endpackage

@@ src/mbe_cell.sv @@
// One multiplier cell: folds one digit of the multiplier into three partial products.
module mbe_cell (
  input  logic          clk,
  input  logic          rst,
  input  mbe_pkg::cell_t cell_in,
  output mbe_pkg::cell_t cell_out
);
  import mbe_pkg::*;

  logic signed [DIGIT_W:0]  dig_re;
  logic signed [DIGIT_W:0]  dig_im;
  logic signed [ACC_W-1:0]  sum_aa;
  logic signed [ACC_W-1:0]  sum_bb;
  logic signed [ACC_W-1:0]  sum_ab;

  // low digit of the multiplier, unsigned; sign handled after the chain
  assign dig_re = $signed({1'b0, cell_in.y_re[DIGIT_W-1:0]});
  assign dig_im = $signed({1'b0, cell_in.y_im[DIGIT_W-1:0]});

  assign sum_aa = cell_in.hi_aa + ACC_W'(cell_in.x_re * dig_re);
  assign sum_bb = cell_in.hi_bb + ACC_W'(cell_in.x_im * dig_im);
  assign sum_ab = cell_in.hi_ab + ACC_W'(cell_in.x_re * dig_im);

  // shift the finished digit into the low word, pass the rest on
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= cell_in.valid;
    end
    cell_out.x_re  <= cell_in.x_re;
    cell_out.x_im  <= cell_in.x_im;
    cell_out.y_re  <= cell_in.y_re >>> DIGIT_W;
    cell_out.y_im  <= cell_in.y_im >>> DIGIT_W;
    cell_out.hi_aa <= sum_aa >>> DIGIT_W;
    cell_out.hi_bb <= sum_bb >>> DIGIT_W;
    cell_out.hi_ab <= sum_ab >>> DIGIT_W;
    cell_out.lo_aa <= {sum_aa[DIGIT_W-1:0], cell_in.lo_aa[Z_W-1:DIGIT_W]};
    cell_out.lo_bb <= {sum_bb[DIGIT_W-1:0], cell_in.lo_bb[Z_W-1:DIGIT_W]};
    cell_out.lo_ab <= {sum_ab[DIGIT_W-1:0], cell_in.lo_ab[Z_W-1:DIGIT_W]};
  end

endmodule

@@ src/mandelbrot_escape_time.sv @@
// Top level: escape-time iteration controller around a chain of multiplier cells.
// Each point is iterated z <- z*z + c from z = c. A pass runs through the chain
// of digit cells that form a*a, b*b and a*b; the products are then finished,
// scaled and registered in sa, sb and p. z is tested and updated at the edge
// that feeds the next pass into the chain. A point needs one pass per iteration
// when it reaches the limit and one more when it escapes; its result beat is
// offered after the last pass and waits while the output register is full. The
// next point is taken after that, so the limit sets the worst case.
// A new point is taken once the previous result sits in the output register;
// the result waits there until taken. Registers: index 0 iteration limit,
// index 1 escape threshold.
module mandelbrot_escape_time (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mbe_pkg::C_W-1:0]      c_real,
  input  logic signed [mbe_pkg::C_W-1:0]      c_imag,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mbe_pkg::COUNT_WIDTH-1:0]     iterations,
  output logic signed [mbe_pkg::Z_W-1:0]      final_real,
  output logic signed [mbe_pkg::Z_W-1:0]      final_imag,
  output logic                                escaped,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbe_pkg::IDX_W-1:0]           cfg_index,
  input  logic [mbe_pkg::THR_W-1:0]           cfg_data
);
  import mbe_pkg::*;

  state_t state, state_next;

  logic [COUNT_WIDTH-1:0]  limit_reg;
  logic [THR_W-1:0]        thr_reg;

  logic signed [Z_W-1:0]   z_re, z_re_next, z_im, z_im_next;
  logic signed [C_W-1:0]   c_re, c_re_next, c_im, c_im_next;
  logic [COUNT_WIDTH-1:0]  count, count_next;
  logic                    first, first_next;
  logic signed [SQ_W-1:0]  sa, sa_next, sb, sb_next, p, p_next;

  logic                    out_valid_next;
  logic [COUNT_WIDTH-1:0]  iterations_next;
  logic signed [Z_W-1:0]   final_real_next, final_imag_next;
  logic                    escaped_next;

  logic                    inject;
  cell_t                   link [NUM_CELLS+1];

  logic signed [ACC_W-1:0]  hi_aa, hi_bb, hi_ab;
  logic signed [FULL_W-1:0] full_aa, full_bb, full_ab;
  logic signed [SQ_W-1:0]   new_re_w, new_im_w;
  logic signed [Z_W-1:0]    new_re, new_im;
  logic [SQ_W-1:0]          mag;
  logic                     esc_hit;
  logic [COUNT_WIDTH-1:0]   count_inc;
  logic                     out_free;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= COUNT_WIDTH'(64);
      thr_reg   <= THR_W'(32'h4000_0000);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LIMIT) begin
        limit_reg <= cfg_data[COUNT_WIDTH-1:0];
      end
      if (cfg_index == REG_THRESHOLD) begin
        thr_reg <= cfg_data;
      end
    end
  end

  // Chain feed: the current (or newly loaded) z enters cell 0
  always_comb begin
    link[0]       = '0;
    link[0].valid = inject;
    link[0].x_re  = z_re_next;
    link[0].x_im  = z_im_next;
    link[0].y_re  = z_re_next;
    link[0].y_im  = z_im_next;
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    mbe_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_in  (link[g]),
      .cell_out (link[g+1])
    );
  end

  // Finish products: correct for a negative multiplier, then join high and low words
  always_comb begin
    hi_aa = link[NUM_CELLS].hi_aa
            - (link[NUM_CELLS].y_re[Z_W-1] ? ACC_W'(link[NUM_CELLS].x_re) : '0);
    hi_bb = link[NUM_CELLS].hi_bb
            - (link[NUM_CELLS].y_im[Z_W-1] ? ACC_W'(link[NUM_CELLS].x_im) : '0);
    hi_ab = link[NUM_CELLS].hi_ab
            - (link[NUM_CELLS].y_im[Z_W-1] ? ACC_W'(link[NUM_CELLS].x_re) : '0);
    full_aa = $signed({hi_aa, link[NUM_CELLS].lo_aa});
    full_bb = $signed({hi_bb, link[NUM_CELLS].lo_bb});
    full_ab = $signed({hi_ab, link[NUM_CELLS].lo_ab});
  end

  // Update terms for the step state
  always_comb begin
    new_re_w  = sa - sb + SQ_W'(c_re);
    new_im_w  = p + SQ_W'(c_im);
    mag       = $unsigned(sa) + $unsigned(sb);
    esc_hit   = !first && (mag > SQ_W'(thr_reg));
    count_inc = first ? count : count + 1'b1;
    out_free  = !out_valid || !out_stall;
    if (new_re_w > SQ_W'(Z_MAX)) begin
      new_re = Z_MAX;
    end else if (new_re_w < SQ_W'(Z_MIN)) begin
      new_re = Z_MIN;
    end else begin
      new_re = new_re_w[Z_W-1:0];
    end
    if (new_im_w > SQ_W'(Z_MAX)) begin
      new_im = Z_MAX;
    end else if (new_im_w < SQ_W'(Z_MIN)) begin
      new_im = Z_MIN;
    end else begin
      new_im = new_im_w[Z_W-1:0];
    end
  end

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    z_re       <= z_re_next;
    z_im       <= z_im_next;
    c_re       <= c_re_next;
    c_im       <= c_im_next;
    count      <= count_next;
    first      <= first_next;
    sa         <= sa_next;
    sb         <= sb_next;
    p          <= p_next;
    iterations <= iterations_next;
    final_real <= final_real_next;
    final_imag <= final_imag_next;
    escaped    <= escaped_next;
  end

  // Next state and outputs
  always_comb begin
    state_next      = state;
    z_re_next       = z_re;
    z_im_next       = z_im;
    c_re_next       = c_re;
    c_im_next       = c_im;
    count_next      = count;
    first_next      = first;
    sa_next         = sa;
    sb_next         = sb;
    p_next          = p;
    inject          = 1'b0;
    out_valid_next  = out_valid && out_stall;
    iterations_next = iterations;
    final_real_next = final_real;
    final_imag_next = final_imag;
    escaped_next    = escaped;
    in_stall        = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          c_re_next  = c_real;
          c_im_next  = c_imag;
          z_re_next  = Z_W'(c_real);
          z_im_next  = Z_W'(c_imag);
          count_next = COUNT_WIDTH'(1);
          first_next = 1'b1;
          inject     = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (link[NUM_CELLS].valid) begin
          sa_next    = SQ_W'(full_aa >>> FRAC_BITS);
          sb_next    = SQ_W'(full_bb >>> FRAC_BITS);
          p_next     = SQ_W'(full_ab >>> (FRAC_BITS - 1));
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (esc_hit || count_inc >= limit_reg) begin
          // result beat; waits here while the output register is full
          if (out_free) begin
            out_valid_next  = 1'b1;
            iterations_next = esc_hit ? count : count_inc;
            final_real_next = z_re;
            final_imag_next = z_im;
            escaped_next    = esc_hit;
            state_next      = ST_IDLE;
          end
        end else begin
          z_re_next  = new_re;
          z_im_next  = new_im;
          count_next = count_inc;
          first_next = 1'b0;
          inject     = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Checks
  a_iter_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> iterations != '0)
    else $error("result with zero iteration count");

  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !escaped) |->
      (iterations == limit_reg || (limit_reg <= COUNT_WIDTH'(1) && iterations == 1'b1)))
    else $error("non-escaped result count differs from limit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && !first) |-> count < limit_reg)
    else $error("iteration count passed the limit");

  a_chain_run: assert property (@(posedge clk) disable iff (rst)
    link[NUM_CELLS].valid |-> state == ST_RUN)
    else $error("product beat left the chain outside the run state");

  a_step_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && link[NUM_CELLS].valid) |=> state == ST_STEP)
    else $error("finished products not taken into the step state");

endmodule
